// ===== rtl/ibf_pkg.sv =====
// shared types, constants and helpers of the ip ban filter table
`default_nettype none
package ibf_pkg;

    localparam int DEPTH  = 32;
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = 6;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [2:0] MODE_LOOKUP  = 3'd0;
    localparam logic [2:0] MODE_ADD     = 3'd1;
    localparam logic [2:0] MODE_RM_SLOT = 3'd2;
    localparam logic [2:0] MODE_RM_ADDR = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_SLOT  = 2'd3;

    localparam logic [1:0] FM_OFF     = 2'd0;
    localparam logic [1:0] FM_DISCARD = 2'd1;

    typedef struct packed {
        logic [31:0] addr;
        logic [3:0]  mask;
        logic [31:0] len;
        logic [31:0] endt;
    } entry_t;

    // query broadcast to every cell
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] cmp;
        logic [3:0]  mask;
        logic [31:0] now;
    } query_t;

    typedef struct packed {
        logic expired;
        logic lk_match;
        logic ex_match;
        logic ones;
    } flags_t;

    function automatic logic [3:0] octet_mask_of(input logic [31:0] a);
        logic [3:0] m;
        m[3] = (a[31:24] != 8'd0);
        m[2] = (a[23:16] != 8'd0);
        m[1] = (a[15:8]  != 8'd0);
        m[0] = (a[7:0]   != 8'd0);
        return m;
    endfunction

    function automatic logic [31:0] expand_mask(input logic [3:0] m);
        return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ibf_cell.sv =====
// one table entry with its match and expiry flags and a shift from the upper neighbor
`default_nettype none
module ibf_cell
    import ibf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire query_t query,
    input  wire logic   load,
    input  wire entry_t wr_entry,
    input  wire logic   rm_load,
    input  wire logic   rm_set,
    input  wire logic   compact,
    input  wire entry_t nb_entry,
    input  wire logic   nb_rm,
    input  wire logic   found_in,
    output logic        found_out,
    output entry_t      entry,
    output logic        rm,
    output flags_t      flags
);

    entry_t entry_reg;
    logic   rm_reg;
    logic   shift;

    // this cell or one below it is the lowest one being removed
    assign found_out = found_in | rm_reg;
    assign shift     = compact & found_out;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= wr_entry;
        end
        else if (shift)
        begin
            entry_reg <= nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_reg <= 1'b0;
        end
        else if (rm_load)
        begin
            rm_reg <= rm_set;
        end
        else if (shift)
        begin
            rm_reg <= nb_rm;
        end
    end

    assign entry = entry_reg;
    assign rm    = rm_reg;

    assign flags.expired  = (entry_reg.addr != ALL_ONES) && (entry_reg.len != 32'd0)
                            && (entry_reg.endt <= query.now);
    assign flags.lk_match = ((query.addr & expand_mask(entry_reg.mask)) == entry_reg.addr);
    assign flags.ex_match = (entry_reg.addr == query.cmp) && (entry_reg.mask == query.mask);
    assign flags.ones     = (entry_reg.addr == ALL_ONES);

endmodule
`default_nettype wire

// ===== rtl/ip_ban_filter_table.sv =====
// top level of the ip ban filter table: control, result register and the row of entry cells
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | mode address slot duration_seconds now_time
//  out     | out_valid | out_stall | discard status result_slot entry_* outputs
//  cfg     | cfg_write_en          | cfg_write_data (filter_mode)
//
// one item at a time: accept, evaluate, then one compact step per removed
// entry plus a final check, then the result waits in its register
// a lookup can drop all 32 entries; the compact loop removes them one entry
// per cycle through the cell chain
// reset clears the entry count and sets filter_mode to discard matches
// in_stall is high from accept until the result item is taken
`default_nettype none
module ip_ban_filter_table
    import ibf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         mode,
    input  wire logic [31:0]        address,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [31:0]        duration_seconds,
    input  wire logic [31:0]        now_time,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    discard,
    output logic [1:0]              status,
    output logic [SLOT_W-1:0]       result_slot,
    output logic [31:0]             entry_address_out,
    output logic [31:0]             entry_duration_out,
    output logic [SLOT_W-1:0]       entry_count_out
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EVAL    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;
    localparam logic [1:0] S_OUT     = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        fm_reg;
    logic [SLOT_W-1:0] total_reg, total_next;

    // latched item
    logic [2:0]        mode_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       dur_reg;
    query_t            query_reg;

    // result register
    logic              discard_reg, discard_next;
    logic [1:0]        status_reg, status_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [31:0]       eaddr_reg, eaddr_next;
    logic [31:0]       edur_reg, edur_next;

    // cell chain
    entry_t            ent [DEPTH];
    flags_t            flg [DEPTH];
    logic [DEPTH-1:0]  rm_v;
    logic [DEPTH:0]    found;
    logic [DEPTH-1:0]  load_v;
    logic [DEPTH-1:0]  rm_set_v;
    entry_t            wr_entry;
    logic              in_eval;
    logic              in_compact;

    // per-cell qualified flags
    logic [DEPTH-1:0]  valid_v;
    logic [DEPTH-1:0]  exp_v;
    logic [DEPTH-1:0]  hit_v;
    logic [DEPTH-1:0]  free_v;
    logic [DEPTH-1:0]  exact_v;

    logic              hit_any;
    logic [IW-1:0]     hit_idx;
    logic              free_any;
    logic [IW-1:0]     free_idx;
    logic              exact_any;
    logic [IW-1:0]     exact_idx;
    logic [IW-1:0]     wr_idx;
    logic [IW-1:0]     rd_idx;
    logic [32:0]       end_sum;
    logic [31:0]       end_sat;

    assign in_eval    = (state_reg == S_EVAL);
    assign in_compact = (state_reg == S_COMPACT);
    assign found[0]   = 1'b0;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        entry_t nb_e;
        logic   nb_r;
        if (j == DEPTH - 1)
        begin : g_top
            assign nb_e = '0;
            assign nb_r = 1'b0;
        end
        else
        begin : g_mid
            assign nb_e = ent[j+1];
            assign nb_r = rm_v[j+1];
        end

        ibf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .query    (query_reg),
            .load     (load_v[j]),
            .wr_entry (wr_entry),
            .rm_load  (in_eval),
            .rm_set   (rm_set_v[j]),
            .compact  (in_compact),
            .nb_entry (nb_e),
            .nb_rm    (nb_r),
            .found_in (found[j]),
            .found_out(found[j+1]),
            .entry    (ent[j]),
            .rm       (rm_v[j]),
            .flags    (flg[j])
        );

        assign valid_v[j] = (SLOT_W'(j) < total_reg);
        assign exp_v[j]   = valid_v[j] & flg[j].expired;
        assign hit_v[j]   = valid_v[j] & ~flg[j].expired & flg[j].lk_match;
        assign free_v[j]  = valid_v[j] & (flg[j].ones | flg[j].ex_match);
        assign exact_v[j] = valid_v[j] & flg[j].ex_match;
    end

    // highest hit, lowest reusable slot, lowest exact match
    always_comb
    begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        exact_any = 1'b0;
        exact_idx = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (hit_v[j])
            begin
                hit_any = 1'b1;
                hit_idx = IW'(j);
            end
        end
        for (int j = DEPTH - 1; j >= 0; j--)
        begin
            if (free_v[j])
            begin
                free_any = 1'b1;
                free_idx = IW'(j);
            end
            if (exact_v[j])
            begin
                exact_any = 1'b1;
                exact_idx = IW'(j);
            end
        end
    end

    // saturating end time
    assign end_sum = {1'b0, query_reg.now} + {1'b0, dur_reg};
    assign end_sat = end_sum[32] ? ALL_ONES : end_sum[31:0];

    assign wr_entry.addr = query_reg.cmp;
    assign wr_entry.mask = query_reg.mask;
    assign wr_entry.len  = dur_reg;
    assign wr_entry.endt = (dur_reg != 32'd0) ? end_sat : 32'd0;

    // evaluate step
    always_comb
    begin
        load_v       = '0;
        rm_set_v     = '0;
        total_next   = total_reg;
        discard_next = 1'b0;
        status_next  = ST_OK;
        rslot_next   = '0;
        eaddr_next   = 32'd0;
        edur_next    = 32'd0;
        wr_idx       = '0;
        rd_idx       = '0;
        case (mode_reg)
            MODE_LOOKUP:
            begin
                if (fm_reg != FM_OFF)
                begin
                    // expired entries above the hit go, or all of them on a miss
                    for (int j = 0; j < DEPTH; j++)
                    begin
                        rm_set_v[j] = exp_v[j] & (~hit_any | (IW'(j) > hit_idx));
                    end
                    if (hit_any)
                    begin
                        rd_idx       = hit_idx;
                        rslot_next   = SLOT_W'(hit_idx) + SLOT_W'(1);
                        eaddr_next   = ent[rd_idx].addr;
                        edur_next    = ent[rd_idx].len;
                        discard_next = (fm_reg == FM_DISCARD);
                    end
                    else
                    begin
                        discard_next = (fm_reg != FM_DISCARD);
                        status_next  = ST_NOT_FOUND;
                    end
                end
            end
            MODE_ADD:
            begin
                if (free_any || total_reg < SLOT_W'(DEPTH))
                begin
                    if (free_any)
                    begin
                        wr_idx = free_idx;
                    end
                    else
                    begin
                        wr_idx     = total_reg[IW-1:0];
                        total_next = total_reg + SLOT_W'(1);
                    end
                    load_v[wr_idx] = 1'b1;
                    rslot_next     = SLOT_W'(wr_idx) + SLOT_W'(1);
                    eaddr_next     = query_reg.cmp;
                    edur_next      = dur_reg;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            MODE_RM_SLOT, MODE_READ:
            begin
                if (slot_reg == '0 || slot_reg > total_reg)
                begin
                    status_next = ST_BAD_SLOT;
                end
                else
                begin
                    rd_idx     = IW'(slot_reg - SLOT_W'(1));
                    rslot_next = slot_reg;
                    eaddr_next = ent[rd_idx].addr;
                    edur_next  = ent[rd_idx].len;
                    if (mode_reg == MODE_RM_SLOT)
                    begin
                        rm_set_v[rd_idx] = 1'b1;
                    end
                end
            end
            MODE_RM_ADDR:
            begin
                if (exact_any)
                begin
                    rd_idx           = exact_idx;
                    rslot_next       = SLOT_W'(exact_idx) + SLOT_W'(1);
                    eaddr_next       = ent[rd_idx].addr;
                    edur_next        = ent[rd_idx].len;
                    rm_set_v[rd_idx] = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (!in_eval)
        begin
            load_v   = '0;
            rm_set_v = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                // one removal per cycle until no flag is left
                if (!found[DEPTH])
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            fm_reg    <= FM_DISCARD;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                fm_reg <= cfg_write_data;
            end
            if (in_eval)
            begin
                total_reg <= total_next;
            end
            else if (in_compact && found[DEPTH])
            begin
                total_reg <= total_reg - SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            mode_reg       <= mode;
            slot_reg       <= slot;
            dur_reg        <= duration_seconds;
            query_reg.addr <= address;
            query_reg.mask <= octet_mask_of(address);
            query_reg.cmp  <= address & expand_mask(octet_mask_of(address));
            query_reg.now  <= now_time;
        end
        if (in_eval)
        begin
            discard_reg <= discard_next;
            status_reg  <= status_next;
            rslot_reg   <= rslot_next;
            eaddr_reg   <= eaddr_next;
            edur_reg    <= edur_next;
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = (state_reg == S_OUT);
    assign discard            = discard_reg;
    assign status             = status_reg;
    assign result_slot        = rslot_reg;
    assign entry_address_out  = eaddr_reg;
    assign entry_duration_out = edur_reg;
    assign entry_count_out    = total_reg;

`ifndef SYNTH
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while input open");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= SLOT_W'(DEPTH))
        else $error("entry count beyond table depth");
    a_compact_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        in_compact |=> total_reg <= $past(total_reg))
        else $error("count grew while compacting");
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> result_slot == '0)
        else $error("full table reported a slot");
`endif

endmodule
`default_nettype wire
